/* src/sct_pkg.sv */
// shared types and codes for the command-line tokenizer
`default_nettype none

package sct_pkg;

	// result kinds
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_EOT  = 2'd1;
	localparam logic [1:0] KIND_EOL  = 2'd2;

	// most results one input byte can cause
	localparam int MAX_RES = 3;

	// lexer modes, one-hot
	typedef enum logic [4:0] {
		MODE_NORMAL = 5'b00001,
		MODE_ESC    = 5'b00010,
		MODE_SQ     = 5'b00100,
		MODE_DQ     = 5'b01000,
		MODE_DQ_ESC = 5'b10000
	} lex_mode_t;

	// input beat
	typedef struct packed {
		logic [7:0] ch;
		logic       end_line;
	} in_beat_t;

	// result beat
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_out;
		logic       run_last;
	} out_beat_t;

	// classified work for one input byte, passed from front to back
	typedef struct packed {
		logic [1:0]         count;
		logic [2:0][1:0]    kinds;
		logic [7:0]         ch;
	} entry_t;

endpackage

`default_nettype wire

/* src/sct_front.sv */
// front end: accepts bytes, tracks quoting state and classifies each byte
`default_nettype none

module sct_front (
	input  wire                logic             clk,
	input  wire                logic             arst_n,
	input  wire                logic             accept,
	input  wire sct_pkg::in_beat_t               item,
	output logic                                 wr_en,
	output sct_pkg::entry_t                      wr_data
);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AMP    = 8'h26;

	sct_pkg::lex_mode_t mode_q, mode_d;
	logic               open_q, open_d;
	logic [1:0]         n;
	logic [2:0][1:0]    kinds;
	logic               eol, is_space;

	// classify the byte and list the results it causes
	always_comb begin
		mode_d   = mode_q;
		open_d   = open_q;
		n        = 2'd0;
		kinds    = '0;
		eol      = item.end_line || (item.ch == CH_NUL);
		is_space = (item.ch == CH_SPACE) || (item.ch >= CH_TAB && item.ch <= CH_CR);
		if (eol) begin
			if (open_q) begin
				kinds[n] = sct_pkg::KIND_EOT;
				n        = n + 2'd1;
			end
			kinds[n] = sct_pkg::KIND_EOL;
			n        = n + 2'd1;
			mode_d   = sct_pkg::MODE_NORMAL;
			open_d   = 1'b0;
		end else begin
			case (mode_q)
				sct_pkg::MODE_ESC: begin
					kinds[n] = sct_pkg::KIND_CHAR;
					n        = n + 2'd1;
					open_d   = 1'b1;
					mode_d   = sct_pkg::MODE_NORMAL;
				end
				sct_pkg::MODE_SQ: begin
					if (item.ch == CH_SQUOTE) begin
						mode_d = sct_pkg::MODE_NORMAL;
					end else begin
						kinds[n] = sct_pkg::KIND_CHAR;
						n        = n + 2'd1;
						open_d   = 1'b1;
					end
				end
				sct_pkg::MODE_DQ: begin
					if (item.ch == CH_DQUOTE) begin
						mode_d = sct_pkg::MODE_NORMAL;
					end else if (item.ch == CH_BSLASH) begin
						mode_d = sct_pkg::MODE_DQ_ESC;
					end else begin
						kinds[n] = sct_pkg::KIND_CHAR;
						n        = n + 2'd1;
						open_d   = 1'b1;
					end
				end
				sct_pkg::MODE_DQ_ESC: begin
					kinds[n] = sct_pkg::KIND_CHAR;
					n        = n + 2'd1;
					open_d   = 1'b1;
					mode_d   = sct_pkg::MODE_DQ;
				end
				default: begin
					mode_d = sct_pkg::MODE_NORMAL;
					if (is_space) begin
						if (open_q) begin
							kinds[n] = sct_pkg::KIND_EOT;
							n        = n + 2'd1;
						end
						open_d = 1'b0;
					end else if (item.ch == CH_BSLASH) begin
						mode_d = sct_pkg::MODE_ESC;
					end else if (item.ch == CH_SQUOTE) begin
						mode_d = sct_pkg::MODE_SQ;
					end else if (item.ch == CH_DQUOTE) begin
						mode_d = sct_pkg::MODE_DQ;
					end else if (item.ch == CH_LT || item.ch == CH_GT) begin
						// redirection is a token of its own
						if (open_q) begin
							kinds[n] = sct_pkg::KIND_EOT;
							n        = n + 2'd1;
						end
						kinds[n] = sct_pkg::KIND_CHAR;
						n        = n + 2'd1;
						kinds[n] = sct_pkg::KIND_EOT;
						n        = n + 2'd1;
						open_d   = 1'b0;
					end else if (item.ch == CH_PIPE || item.ch == CH_SEMI
							|| item.ch == CH_AMP) begin
						// operator starts a new token
						if (open_q) begin
							kinds[n] = sct_pkg::KIND_EOT;
							n        = n + 2'd1;
						end
						kinds[n] = sct_pkg::KIND_CHAR;
						n        = n + 2'd1;
						open_d   = 1'b1;
					end else begin
						kinds[n] = sct_pkg::KIND_CHAR;
						n        = n + 2'd1;
						open_d   = 1'b1;
					end
				end
			endcase
		end
	end

	// hand work to the queue only when there is a result
	assign wr_en         = accept && (n != 2'd0);
	assign wr_data.count = n;
	assign wr_data.kinds = kinds;
	assign wr_data.ch    = item.ch;

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sct_pkg::MODE_NORMAL;
			open_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			open_q <= open_d;
		end
	end

endmodule

`default_nettype wire

/* src/sct_queue.sv */
// short queue of classified entries between front and back
`default_nettype none

module sct_queue #(
	parameter int DEPTH = 4
) (
	input  wire             logic clk,
	input  wire             logic arst_n,
	input  wire             logic wr_en,
	input  wire sct_pkg::entry_t  wr_data,
	input  wire             logic rd_en,
	output sct_pkg::entry_t       rd_data,
	output logic                  empty,
	output logic                  full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sct_pkg::entry_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign rd_data = slot_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !wr_en)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !rd_en)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

/* src/sct_back.sv */
// back end: steps through the results of the head entry, one beat per pop
`default_nettype none

module sct_back (
	input  wire             logic clk,
	input  wire             logic arst_n,
	input  wire sct_pkg::entry_t  head,
	input  wire             logic q_empty,
	input  wire             logic pop,
	output logic                  rd_en,
	output sct_pkg::out_beat_t    result
);

	logic [1:0] idx_q;
	logic       last, pop_ok;

	assign last   = (idx_q == head.count - 2'd1);
	assign pop_ok = pop && !q_empty;
	assign rd_en  = pop_ok && last;

	// current result beat
	assign result.kind     = head.kinds[idx_q];
	assign result.char_out = (head.kinds[idx_q] == sct_pkg::KIND_CHAR) ? head.ch : 8'h00;
	assign result.run_last = last;

	// position within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (pop_ok) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	a_idx_in_entry: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (idx_q < head.count))
		else $error("result index past end of entry");
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		pop_ok && !last |=> idx_q == $past(idx_q) + 2'd1)
		else $error("result index did not advance");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> idx_q == 2'd0)
		else $error("result index not cleared between entries");

endmodule

`default_nettype wire

/* src/shell_command_tokenizer.sv */
// Command-line tokenizer top level.
//
// Input channel: push/full with one byte (or an end-of-line mark) per beat.
// A beat is taken when push is high and full is low. A zero byte acts as
// end of line. Result channel: empty/pop; the oldest result beat sits on
// result while empty is low and is taken when pop is high.
// Each input beat causes zero to three result beats (token character,
// end of token, end of line); run_last marks the last one of each input.
// Classified entries are registered in the entry queue before they reach result.
// Throughput: one input beat per cycle while full is low; the back end
// drains one result beat per cycle, so bytes that expand to two or three
// results fill the entry queue of QUEUE_DEPTH entries, and full rises once
// it holds QUEUE_DEPTH. When the receiver stalls, entries wait in the queue
// and the front keeps taking bytes until the queue is full. Reset empties
// the queue and returns the lexer to plain mode with no token open.
`default_nettype none

module shell_command_tokenizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic push,
	output logic                     full,
	input  wire sct_pkg::in_beat_t   item,
	output logic                     empty,
	input  wire                logic pop,
	output sct_pkg::out_beat_t       result
);

	logic            wr_en, rd_en;
	sct_pkg::entry_t wr_data, head;

	sct_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (push && !full),
		.item    (item),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	sct_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_data (head),
		.empty   (empty),
		.full    (full)
	);

	sct_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (empty),
		.pop     (pop),
		.rd_en   (rd_en),
		.result  (result)
	);

endmodule

`default_nettype wire
